>>> rtl/core/edf_pkg.sv
// ============================================================================
// edf_pkg: shared types and constants for the EDF task scheduler
// Word layouts, kind and status codes, controller states and command/status
// bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package edf_pkg;

  localparam int MAX_TASKS_DEFAULT = 16;

  // item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  // task status codes
  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_INERT   = 2'd3;  // stored as loaded; a tick renewal or a start can change it

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    logic [31:0] entry_deadline;
    logic [31:0] entry_period;
    logic [1:0]  entry_status;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  running_task;
    logic        switched;
    logic        went_idle;
    logic [31:0] time_now;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_TICK,
    S_CURDL,
    S_WALK_T,
    S_MARK,
    S_WALK_R,
    S_FINAL,
    S_WALK_S,
    S_RDCUR,
    S_STWB,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    WALK_TICK,
    WALK_RESCHED,
    WALK_START
  } walk_mode_t;

  typedef struct packed {
    logic       capture;     // latch incoming word, reset walk and search
    logic       do_load;
    logic       tick_inc;
    logic       rd_cur;
    logic       cur_dl_load;
    logic       walk_start;
    logic       walk_run;
    walk_mode_t mode;
    logic       mark;
    logic [1:0] mark_val;
    logic       finalize;
    logic       set_cur_pick;
    logic       start_wb;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       flag;
    logic       walk_done;
    logic       out_busy;
    logic       out_valid;
  } sts_t;

  // 32-bit wrapping add; an all-ones sum folds to zero
  function automatic logic [31:0] wrap_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return (s == 32'hFFFF_FFFF) ? 32'd0 : s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/edf_datapath.sv
// ============================================================================
// edf_datapath: task tables, system clock and walk engine
// Holds the three task memories, the running task, the search registers and
// the output word register. Driven by command bits from edf_ctrl.
// ============================================================================
`default_nettype none

module edf_datapath
  import edf_pkg::*;
#(
  parameter int MaxTasks = MAX_TASKS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_valid,
  input  wire logic [4:0] cfg_data,
  input  wire in_word_t  in_data,
  input  wire cmd_t      cmd,
  output sts_t           sts,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int AW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam logic [4:0] WalkMax = (MaxTasks < 16) ? 5'(MaxTasks) : 5'd16;

  logic [31:0] dl_mem  [MaxTasks];
  logic [31:0] per_mem [MaxTasks];
  logic [1:0]  st_mem  [MaxTasks];

  logic [31:0] rd_dl, rd_per;
  logic [1:0]  rd_st;
  logic [AW-1:0] raddr;

  in_word_t    item;
  logic [4:0]  task_count;
  logic [31:0] clock;
  logic [3:0]  cur;
  logic [31:0] cur_dl;
  logic        flag;
  logic [31:0] best;
  logic [3:0]  pick;
  logic        sw, idle;
  logic [4:0]  widx;
  logic [3:0]  didx;
  logic        pend;
  logic [4:0]  walk_n;

  logic        dl_we, per_we, st_we;
  logic [AW-1:0] dl_wa, st_wa;
  logic [31:0] dl_wd;
  logic [1:0]  st_wd;

  logic        data_ph, renew, load_ok;
  logic [31:0] new_dl;
  logic [3:0]  fin_task;

  assign walk_n   = (task_count > WalkMax) ? WalkMax : task_count;
  assign data_ph  = cmd.walk_run && pend;
  assign renew    = (rd_dl == clock);
  assign new_dl   = wrap_add(rd_dl, rd_per);
  assign load_ok  = (32'(item.entry_index) < 32'(MaxTasks));
  assign fin_task = (pick != cur) ? pick : 4'd0;

  always_comb begin
    if (cmd.rd_cur) begin
      raddr = AW'(cur);
    end else if (cmd.set_cur_pick) begin
      raddr = AW'(pick);
    end else begin
      raddr = AW'(widx);
    end
  end

  // memory write selection; sources never overlap in time
  always_comb begin
    dl_we  = 1'b0;
    per_we = 1'b0;
    st_we  = 1'b0;
    dl_wa  = AW'(didx);
    st_wa  = AW'(didx);
    dl_wd  = new_dl;
    st_wd  = ST_READY;
    if (cmd.do_load && load_ok) begin
      dl_we  = 1'b1;
      per_we = 1'b1;
      st_we  = 1'b1;
      dl_wa  = AW'(item.entry_index);
      st_wa  = AW'(item.entry_index);
      dl_wd  = item.entry_deadline;
      st_wd  = item.entry_status;
    end else if (cmd.start_wb) begin
      dl_we = 1'b1;
      st_we = 1'b1;
      dl_wa = AW'(cur);
      st_wa = AW'(cur);
      st_wd = ST_RUNNING;
    end else if (cmd.mark) begin
      st_we = 1'b1;
      st_wa = AW'(cur);
      st_wd = cmd.mark_val;
    end else if (cmd.finalize) begin
      st_we = 1'b1;
      st_wa = AW'(fin_task);
      st_wd = ST_RUNNING;
    end else if (data_ph && renew && cmd.mode != WALK_START) begin
      dl_we = 1'b1;
      st_we = (cmd.mode == WALK_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_wa] <= dl_wd;
    end
    if (per_we) begin
      per_mem[AW'(item.entry_index)] <= item.entry_period;
    end
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    rd_dl  <= dl_mem[raddr];
    rd_per <= per_mem[raddr];
    rd_st  <= st_mem[raddr];
  end

  // walk sequencer: issue a read, then process its registered data in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      widx <= '0;
    end else if (cmd.capture || cmd.walk_start) begin
      pend <= 1'b0;
      widx <= '0;
    end else if (cmd.walk_run) begin
      pend <= (widx < walk_n);
      didx <= widx[3:0];
      if (widx < walk_n) begin
        widx <= widx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= 5'd1;
      clock      <= '0;
      cur        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        task_count <= cfg_data;
      end
      if (cmd.tick_inc) begin
        clock <= wrap_add(clock, 32'd1);
      end
      if (cmd.finalize) begin
        cur <= fin_task;
      end else if (cmd.set_cur_pick) begin
        cur <= pick;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
      flag <= 1'b0;
      best <= 32'hFFFF_FFFF;
      pick <= cur;
      sw   <= 1'b0;
      idle <= 1'b0;
    end
    if (cmd.cur_dl_load) begin
      cur_dl <= rd_dl;
    end
    if (data_ph) begin
      unique case (cmd.mode)
        WALK_TICK: begin
          if (rd_dl <= cur_dl && rd_st == ST_READY) begin
            flag <= 1'b1;
          end
          if (renew && didx == cur) begin
            cur_dl <= new_dl;
          end
        end
        WALK_RESCHED: begin
          if (rd_st == ST_READY && rd_dl < best) begin
            best <= rd_dl;
            pick <= didx;
          end
        end
        WALK_START: begin
          if (rd_dl < best) begin
            best <= rd_dl;
            pick <= didx;
          end
        end
        default: ;
      endcase
    end
    if (cmd.finalize) begin
      sw   <= 1'b1;
      idle <= (pick == cur);
    end
    if (cmd.start_wb) begin
      sw <= 1'b1;
    end
    if (cmd.out_load) begin
      out_data.running_task <= cur;
      out_data.switched     <= sw;
      out_data.went_idle    <= idle;
      out_data.time_now     <= clock;
    end
  end

  assign sts.kind      = item.kind;
  assign sts.flag      = flag;
  assign sts.walk_done = (widx >= walk_n) && !pend;
  assign sts.out_busy  = out_valid && !out_ready;
  assign sts.out_valid = out_valid;

endmodule

`default_nettype wire

>>> rtl/core/edf_ctrl.sv
// ============================================================================
// edf_ctrl: scheduler sequencer
// Steps each word through its passes over the task table and issues the
// datapath commands.
// ============================================================================
`default_nettype none

module edf_ctrl
  import edf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  output logic            in_ready,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_TICK:  state_next = S_TICK;
            KIND_LOAD:  state_next = S_LOAD;
            KIND_START: state_next = S_WALK_S;
            default:    state_next = S_MARK;
          endcase
        end
      end
      S_LOAD:   state_next = S_DONE;
      S_TICK:   state_next = S_CURDL;
      S_CURDL:  state_next = S_WALK_T;
      S_WALK_T: begin
        if (sts.walk_done) begin
          state_next = sts.flag ? S_MARK : S_DONE;
        end
      end
      S_MARK:   state_next = S_WALK_R;
      S_WALK_R: begin
        if (sts.walk_done) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL:  state_next = S_DONE;
      S_WALK_S: begin
        if (sts.walk_done) begin
          state_next = S_RDCUR;
        end
      end
      S_RDCUR:  state_next = S_STWB;
      S_STWB:   state_next = S_DONE;
      S_DONE: begin
        if (!sts.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mode = WALK_TICK;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_LOAD:  cmd.do_load = 1'b1;
      S_TICK: begin
        cmd.tick_inc = 1'b1;
        cmd.rd_cur   = 1'b1;
      end
      S_CURDL: cmd.cur_dl_load = 1'b1;
      S_WALK_T: begin
        cmd.walk_run = 1'b1;
        cmd.mode     = WALK_TICK;
      end
      S_MARK: begin
        cmd.mark       = 1'b1;
        cmd.mark_val   = (sts.kind == KIND_STOP) ? ST_BLOCKED : ST_READY;
        cmd.walk_start = 1'b1;
      end
      S_WALK_R: begin
        cmd.walk_run = 1'b1;
        cmd.mode     = WALK_RESCHED;
      end
      S_FINAL: cmd.finalize = 1'b1;
      S_WALK_S: begin
        cmd.walk_run = 1'b1;
        cmd.mode     = WALK_START;
      end
      S_RDCUR: cmd.set_cur_pick = 1'b1;
      S_STWB:  cmd.start_wb = 1'b1;
      S_DONE:  cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  // reschedule pass only follows a tick or a stop
  a_resched_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_R) |-> (sts.kind == KIND_TICK || sts.kind == KIND_STOP))
    else $error("reschedule pass for wrong kind");

  // finishing a word always raises the output valid
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !sts.out_busy) |=> sts.out_valid)
    else $error("result word not presented");

  // start writeback comes right after reading the chosen entry
  a_stwb_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_STWB) |-> ($past(state) == S_RDCUR))
    else $error("start writeback out of order");

endmodule

`default_nettype wire

>>> rtl/core/edf_task_scheduler_core.sv
// ============================================================================
// edf_task_scheduler_core: earliest-deadline-first scheduler, top level
// Task table with deadline, period and status per entry; tick, load, start
// and stop words each produce one result word.
// ============================================================================
// Usage:
//   in_valid/in_ready carry one in_word_t; kind selects tick, load, start or
//   stop. Every accepted word yields exactly one out_word_t on
//   out_valid/out_ready, holding the running task, the switch and idle flags
//   and the system time after the word.
//   cfg_valid/cfg_ready write task_count (entries walked, capped at 16 and
//   at MaxTasks). Write it only while no word is in flight.
// Operation:
//   load walks no entries; start and stop walk the table once; a tick walks
//   it once, and again to reschedule when a ready entry has a deadline no
//   later than the running task's. Each table pass issues one memory read
//   per entry and processes its registered read data the next cycle. One
//   word is worked on at a time; the next is taken as soon as the
//   sequencer returns to idle.
// Reset: task 0 running, time zero, task_count 1. Table contents are not
//   cleared and must be loaded before use.
// Stall: a finished word waits in the output register; while out_ready is
//   low the sequencer holds in its finish step and takes no new word.
// ============================================================================
`default_nettype none

module edf_task_scheduler_core
  import edf_pkg::*;
#(
  parameter int MaxTasks = MAX_TASKS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  edf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  edf_datapath #(
    .MaxTasks (MaxTasks)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for edf_task_scheduler_core
// Drives tick, load, start and stop words through the valid/ready channels,
// predicts each result word from a local copy of the task table, clock and
// current task, and compares every field. Phases vary task_count and the
// idle patterns on both sides.
// ============================================================================
`default_nettype none

module tb_top;
  import edf_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;   // settle margin after the last result word

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [4:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  edf_task_scheduler_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Scheduler shadow state
  // --------------------------------------------------------------------------
  logic [31:0] dl_tab [NUM_ENTRIES];
  logic [31:0] per_tab[NUM_ENTRIES];
  logic [1:0]  st_tab [NUM_ENTRIES];
  logic [3:0]  cur_task;
  logic [31:0] sys_time;
  logic [4:0]  task_cnt;

  out_word_t expected_words[$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        cycle_count = 0;

  // wrapping add; an all-ones sum folds to zero
  function automatic logic [31:0] renew_sum(logic [31:0] a, logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return (s == 32'hFFFF_FFFF) ? 32'd0 : s;
  endfunction

  function automatic int walk_len();
    return (task_cnt > NUM_ENTRIES) ? NUM_ENTRIES : int'(task_cnt);
  endfunction

  // pick the ready entry with the smallest deadline, renewing reached
  // deadlines on the way; returns 1 when it falls back to task 0
  function automatic logic pick_earliest();
    logic [31:0] best;
    logic [3:0]  pick;
    best = 32'hFFFF_FFFF;
    pick = cur_task;
    for (int i = 0; i < walk_len(); i++) begin
      if (st_tab[i] == ST_READY && dl_tab[i] < best) begin
        best = dl_tab[i];
        pick = i[3:0];
      end
      if (dl_tab[i] == sys_time) dl_tab[i] = renew_sum(dl_tab[i], per_tab[i]);
    end
    if (pick != cur_task) begin
      st_tab[pick] = ST_RUNNING;
      cur_task = pick;
      return 1'b0;
    end
    st_tab[0] = ST_RUNNING;
    cur_task = '0;
    return 1'b1;
  endfunction

  function automatic out_word_t sched_predict(in_word_t w);
    out_word_t   r;
    logic        hit;
    logic [31:0] best;
    r = '0;
    hit = 1'b0;
    case (w.kind)
      KIND_TICK: begin
        sys_time = renew_sum(sys_time, 32'd1);
        for (int i = 0; i < walk_len(); i++) begin
          // current deadline reread every step: it may be renewed mid-walk
          if (dl_tab[i] <= dl_tab[cur_task] && st_tab[i] == ST_READY) hit = 1'b1;
          if (dl_tab[i] == sys_time) begin
            dl_tab[i] = renew_sum(dl_tab[i], per_tab[i]);
            st_tab[i] = ST_READY;
          end
        end
        if (hit) begin
          st_tab[cur_task] = ST_READY;
          r.went_idle = pick_earliest();
          r.switched = 1'b1;
        end
      end
      KIND_LOAD: begin
        dl_tab[w.entry_index]  = w.entry_deadline;
        per_tab[w.entry_index] = w.entry_period;
        st_tab[w.entry_index]  = w.entry_status;
      end
      KIND_START: begin
        // status ignored here: earliest deadline wins outright
        best = 32'hFFFF_FFFF;
        for (int i = 0; i < walk_len(); i++) begin
          if (dl_tab[i] < best) begin
            best = dl_tab[i];
            cur_task = i[3:0];
          end
        end
        st_tab[cur_task] = ST_RUNNING;
        dl_tab[cur_task] = renew_sum(dl_tab[cur_task], per_tab[cur_task]);
        r.switched = 1'b1;
      end
      default: begin
        st_tab[cur_task] = ST_BLOCKED;
        r.went_idle = pick_earliest();
        r.switched = 1'b1;
      end
    endcase
    r.running_task = cur_task;
    r.time_now = sys_time;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(sched_predict(w));
  endtask

  // wait for every result, then for the sequencer to settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_task_count(logic [4:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    task_cnt = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_word_t mk_word(logic [1:0] k, logic [3:0] idx, logic [31:0] dl,
                                       logic [31:0] per, logic [1:0] st);
    in_word_t w;
    w.kind = k;
    w.entry_index = idx;
    w.entry_deadline = dl;
    w.entry_period = per;
    w.entry_status = st;
    return w;
  endfunction

  function automatic logic [31:0] rand_deadline();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return sys_time + $urandom_range(20);
    if (sel < 80) return 32'd0;
    if (sel < 90) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_period();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(1, 20);
    if (sel < 80) return 32'd0;
    if (sel < 90) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic in_word_t rand_word();
    int sel;
    in_word_t w;
    sel = $urandom_range(99);
    w = mk_word(KIND_TICK, 4'($urandom), $urandom, $urandom, 2'($urandom));
    if (sel < 40) w.kind = KIND_TICK;
    else if (sel < 65) begin
      w = mk_word(KIND_LOAD, 4'($urandom_range(15)), rand_deadline(), rand_period(),
                  2'($urandom_range(3)));
    end else if (sel < 80) w.kind = KIND_START;
    else w.kind = KIND_STOP;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // every entry written first, so no walk ever reads an unwritten entry
  task automatic test_table_fill();
    for (int i = 0; i < NUM_ENTRIES; i++)
      send_word(mk_word(KIND_LOAD, i[3:0], 32'd5 + i, 32'd3 + i, ST_READY));
  endtask

  task automatic test_directed();
    write_task_count(5'd16);
    // deadline + period hitting all-ones folds to zero on renewal
    send_word(mk_word(KIND_LOAD, 4'd1, 32'd1, 32'hFFFF_FFFE, ST_READY));
    send_word(mk_word(KIND_LOAD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_BLOCKED));
    send_word(mk_word(KIND_LOAD, 4'd2, 32'd0, 32'd0, ST_INERT));
    send_word(mk_word(KIND_LOAD, 4'd3, 32'd2, 32'd4, ST_RUNNING));
    send_word(mk_word(KIND_START, '0, '0, '0, '0));
    repeat (4) send_word(mk_word(KIND_TICK, '1, '1, '1, '1));
    send_word(mk_word(KIND_STOP, '0, '0, '0, '0));
    send_word(mk_word(KIND_STOP, '0, '0, '0, '0));
    // nothing ready: stop falls back to task 0
    for (int i = 0; i < NUM_ENTRIES; i++)
      send_word(mk_word(KIND_LOAD, i[3:0], 32'hFFFF_FFFF, 32'd1, ST_BLOCKED));
    send_word(mk_word(KIND_STOP, '0, '0, '0, '0));
    // start with no deadline below all-ones keeps the current task
    send_word(mk_word(KIND_START, '0, '0, '0, '0));
    // zero task count: walks nothing
    write_task_count(5'd0);
    send_word(mk_word(KIND_TICK, '0, '0, '0, '0));
    send_word(mk_word(KIND_START, '0, '0, '0, '0));
    send_word(mk_word(KIND_STOP, '0, '0, '0, '0));
    // count above 16 is capped
    write_task_count(5'd31);
    send_word(mk_word(KIND_LOAD, 4'd9, 32'd0, 32'd7, ST_READY));
    send_word(mk_word(KIND_TICK, '0, '0, '0, '0));
    send_word(mk_word(KIND_START, '0, '0, '0, '0));
  endtask

  task automatic test_random();
    logic [4:0] counts[8] = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8, 5'd2, 5'd16};
    for (int seg = 0; seg < 8; seg++) begin
      write_task_count(counts[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      repeat (115) send_word(rand_word());
    end
  endtask

  initial begin
    task_cnt = 5'd1;
    cur_task = '0;
    sys_time = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_table_fill();
    test_directed();
    test_random();
    drain();
    if (fail_count == 0) $display("** edf_task_scheduler_core: PASSED **");
    else $display("** edf_task_scheduler_core: FAILED **");
    $finish;
  end

  // receiver stalls, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker: oldest expectation against each accepted word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word act=%p", $time, out_data);
        fail_count++;
      end else begin
        if (out_data.running_task !== expected_words[0].running_task ||
            out_data.switched !== expected_words[0].switched ||
            out_data.went_idle !== expected_words[0].went_idle ||
            out_data.time_now !== expected_words[0].time_now) begin
          $display("%0t: mismatch exp=%p act=%p", $time, expected_words[0], out_data);
          fail_count++;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** edf_task_scheduler_core: FAILED **");
      $finish;
    end
  end

endmodule

`default_nettype wire

>>> edf_task_scheduler_core.f
rtl/core/edf_pkg.sv
rtl/core/edf_datapath.sv
rtl/core/edf_ctrl.sv
rtl/core/edf_task_scheduler_core.sv
tb/sv/tb_top.sv
